[hw/rtl/cbh_pkg.sv]
`timescale 1ns / 1ps
package cbh_pkg;

	localparam int unsigned BINS   = 65536;
	localparam int unsigned BIN_W  = $clog2(BINS);
	localparam int unsigned QDEPTH = 4;

	localparam logic [31:0] HIT_MAX     = 32'hFFFF_FFFF;
	localparam logic [7:0]  STALE_MAX   = 8'hFF;
	localparam logic [7:0]  LIMIT_RESET = 8'd5;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_INSTR = 2'd1,
		OP_END   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_BEGIN,
		K_BIN,
		K_END
	} kind_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [47:0] address;
	} in_item_t;

	typedef struct packed {
		logic        counted;
		logic        novel;
		logic [31:0] hit_count;
		logic [7:0]  stale_runs;
		logic        randomize_next;
		logic [31:0] runs_done;
	} out_item_t;

	typedef struct packed {
		kind_t             kind;
		logic [BIN_W-1:0]  bin;
	} cmd_t;

endpackage

[hw/rtl/cbh_ram.sv]
`timescale 1ns / 1ps
module cbh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/cbh_front.sv]
`timescale 1ns / 1ps
module cbh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cbh_pkg::in_item_t in_item,
	input  logic              stall,
	output logic              full,
	output logic              q_push,
	output cbh_pkg::cmd_t     q_data
);
	import cbh_pkg::*;

	logic [47:0] base_address_q;
	logic        base_taken_q;
	logic [47:0] offset;
	logic        in_range;
	logic        accept;

	assign full   = stall;
	assign accept = push && !stall;
	assign q_push = accept;

	assign offset   = in_item.address - base_address_q;
	assign in_range = (offset != 48'd0) && (offset < 48'(BINS));

	always_comb begin
		q_data.bin  = offset[BIN_W-1:0];
		q_data.kind = K_NONE;
		unique case (in_item.operation)
			OP_BEGIN: q_data.kind = K_BEGIN;
			OP_INSTR: q_data.kind = (base_taken_q && in_range) ? K_BIN : K_NONE;
			OP_END:   q_data.kind = K_END;
			default:  q_data.kind = K_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_taken_q   <= 1'b0;
			base_address_q <= 48'd0;
		end else if (accept) begin
			if (in_item.operation == OP_BEGIN) begin
				base_taken_q <= 1'b0;
			end else if (in_item.operation == OP_INSTR && !base_taken_q) begin
				base_taken_q   <= 1'b1;
				base_address_q <= in_item.address;
			end
		end
	end

endmodule

[hw/rtl/cbh_queue.sv]
`timescale 1ns / 1ps
module cbh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cbh_pkg::cmd_t data_in,
	output logic          full,
	input  logic          pop,
	output cbh_pkg::cmd_t data_out,
	output logic          empty
);
	import cbh_pkg::*;

	localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	cmd_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign data_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/cbh_back.sv]
`timescale 1ns / 1ps
module cbh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	input  cbh_pkg::cmd_t      head,
	input  logic               head_empty,
	output logic               head_pop,
	output logic               clearing,
	output logic               empty,
	input  logic               pop,
	output cbh_pkg::out_item_t out_item
);
	import cbh_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_RMW
	} state_t;

	state_t           state_q;
	logic [BIN_W-1:0] clr_idx_q;
	logic [BIN_W-1:0] bin_q;
	logic             run_novel_q;
	logic [7:0]       stale_q;
	logic [31:0]      runs_q;
	logic [7:0]       limit_q;
	out_item_t        out_q;
	logic             out_valid_q;

	logic             out_free;
	logic             ram_we;
	logic [BIN_W-1:0] ram_waddr;
	logic [31:0]      ram_wdata;
	logic [BIN_W-1:0] ram_raddr;
	logic [31:0]      ram_rdata;
	logic             fresh;
	logic [31:0]      bumped;
	logic [7:0]       stale_next;
	logic             out_load;
	out_item_t        out_next;

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign out_item = out_q;
	assign clearing = (state_q == S_CLEAR);
	assign head_pop = (state_q == S_IDLE) && !head_empty && out_free;

	assign fresh      = (ram_rdata == 32'd0);
	assign bumped     = (ram_rdata == HIT_MAX) ? ram_rdata : ram_rdata + 32'd1;
	assign stale_next = run_novel_q ? 8'd0 :
	                    (stale_q == STALE_MAX) ? stale_q : stale_q + 8'd1;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = bin_q;
		ram_wdata = bumped;
		ram_raddr = (state_q == S_IDLE) ? head.bin : bin_q;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_idx_q;
				ram_wdata = 32'd0;
			end
			S_RMW:   ram_we = out_free;
			default: ram_we = 1'b0;
		endcase
	end

	always_comb begin
		out_load            = 1'b0;
		out_next            = '0;
		out_next.stale_runs = stale_q;
		out_next.runs_done  = runs_q;
		unique case (state_q)
			S_IDLE: begin
				if (head_pop) begin
					unique case (head.kind)
						K_END: begin
							out_load                = 1'b1;
							out_next.novel          = run_novel_q;
							out_next.stale_runs     = stale_next;
							out_next.randomize_next = (stale_next > limit_q);
							out_next.runs_done      = runs_q + 32'd1;
						end
						K_BIN:   out_load = 1'b0;
						default: out_load = 1'b1;
					endcase
				end
			end
			S_RMW: begin
				if (out_free) begin
					out_load           = 1'b1;
					out_next.counted   = 1'b1;
					out_next.novel     = fresh;
					out_next.hit_count = bumped;
				end
			end
			default: out_load = 1'b0;
		endcase
	end

	cbh_ram #(
		.WIDTH(32),
		.DEPTH(BINS)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			bin_q       <= '0;
			run_novel_q <= 1'b0;
			stale_q     <= 8'd0;
			runs_q      <= 32'd0;
			limit_q     <= LIMIT_RESET;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (out_load) begin
				out_q       <= out_next;
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == BIN_W'(BINS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head_pop) begin
						unique case (head.kind)
							K_BEGIN: run_novel_q <= 1'b0;
							K_END: begin
								runs_q  <= runs_q + 32'd1;
								stale_q <= stale_next;
							end
							K_BIN: begin
								bin_q   <= head.bin;
								state_q <= S_RMW;
							end
							default: ;
						endcase
					end
				end
				S_RMW: begin
					if (out_free) begin
						if (fresh) begin
							run_novel_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/coverage_bin_histogram.sv]
`timescale 1ns / 1ps
// Takes 1 request per cycle while full is low. An in-range instruction passes the back end as a
// histogram RAM read, then write (IDLE, then RMW state), and output back-pressure stalls the back end;
// a 4-entry command queue absorbs short bursts. Reports leave through a registered output.
// Reset: async, active low. After reset the histogram RAM is cleared one bin per cycle,
// all BINS (65536) bins, with full held high; config writes are taken meanwhile.
module coverage_bin_histogram (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  cbh_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output cbh_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data
);
	import cbh_pkg::*;

	logic q_push;
	cmd_t q_wdata;
	logic q_full;
	logic q_pop;
	cmd_t q_head;
	logic q_empty;
	logic clearing;

	cbh_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_item (in_item),
		.stall   (q_full || clearing),
		.full    (full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	cbh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.data_in  (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.data_out (q_head),
		.empty    (q_empty)
	);

	cbh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.head       (q_head),
		.head_empty (q_empty),
		.head_pop   (q_pop),
		.clearing   (clearing),
		.empty      (empty),
		.pop        (pop),
		.out_item   (out_item)
	);

endmodule

[bench/coverage_bin_histogram_checker.sv]
`timescale 1ns / 1ps
module coverage_bin_histogram_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  cbh_pkg::in_item_t  in_item,
	input  logic               empty,
	input  logic               pop,
	input  cbh_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	output int unsigned        errors,
	output int unsigned        pending,
	output int unsigned        checked
);
	import cbh_pkg::*;

	localparam logic [47:0] BIN_END = 48'(BINS);

	logic [31:0] hits [BINS];
	logic [47:0] base_addr;
	logic        base_set;
	logic        run_fresh;
	logic [7:0]  stale;
	logic [7:0]  limit;
	logic [31:0] runs;
	out_item_t   due_reports [$];
	out_item_t   want;

	function automatic out_item_t step_histogram(in_item_t req);
		out_item_t   r;
		logic [47:0] off;
		logic [31:0] c;
		r = '0;
		case (req.operation)
			OP_BEGIN: begin
				base_set  = 1'b0;
				run_fresh = 1'b0;
			end
			OP_INSTR: begin
				if (!base_set) begin
					base_addr = req.address;
					base_set  = 1'b1;
				end else begin
					off = req.address - base_addr;
					if (off != '0 && off < BIN_END) begin
						c = hits[off[BIN_W-1:0]];
						r.novel = (c == '0);
						if (c == '0)
							run_fresh = 1'b1;
						if (c != HIT_MAX)
							c++;
						hits[off[BIN_W-1:0]] = c;
						r.counted   = 1'b1;
						r.hit_count = c;
					end
				end
			end
			OP_END: begin
				runs++;
				if (run_fresh)
					stale = '0;
				else if (stale != STALE_MAX)
					stale++;
				r.novel          = run_fresh;
				r.randomize_next = (stale > limit);
			end
			default: ;
		endcase
		r.stale_runs = stale;
		r.runs_done  = runs;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (hits[i])
				hits[i] = '0;
			base_addr = '0;
			base_set  = 1'b0;
			run_fresh = 1'b0;
			stale     = '0;
			limit     = LIMIT_RESET;
			runs      = '0;
			due_reports.delete();
			errors    = 0;
			pending   = 0;
			checked   = 0;
		end else begin
			if ($isunknown({full, empty})) begin
				$error("full/empty unknown");
				errors++;
			end
			if (pop && !empty) begin
				if (due_reports.size() == 0) begin
					$error("report popped with no request outstanding");
					errors++;
				end else begin
					want = due_reports.pop_front();
					check_field("counted", 32'(want.counted), 32'(out_item.counted));
					check_field("novel", 32'(want.novel), 32'(out_item.novel));
					check_field("hit_count", want.hit_count, out_item.hit_count);
					check_field("stale_runs", 32'(want.stale_runs),
						32'(out_item.stale_runs));
					check_field("randomize_next", 32'(want.randomize_next),
						32'(out_item.randomize_next));
					check_field("runs_done", want.runs_done, out_item.runs_done);
					checked++;
				end
			end
			if (push && !full)
				due_reports.push_back(step_histogram(in_item));
			if (cfg_we)
				limit = cfg_data;
			pending = due_reports.size();
		end
	end

endmodule

[bench/coverage_bin_histogram_test.sv]
`timescale 1ns / 1ps
module coverage_bin_histogram_test;
	import cbh_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        empty;
	logic        pop;
	logic        cfg_we;
	logic [7:0]  cfg_data;
	in_item_t    in_item;
	out_item_t   out_item;
	int unsigned errors;
	int unsigned pending;
	int unsigned checked;
	int unsigned tx_idle;
	int unsigned rx_idle;
	int unsigned sent;
	logic [47:0] run_base;
	logic [7:0]  last_limit;

	coverage_bin_histogram u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	coverage_bin_histogram_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_item  (in_item),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending),
		.checked  (checked)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= rx_idle);
	end

	function automatic logic [47:0] rand_addr();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	// instruction addresses around the current base, biased to reuse a few bins
	function automatic logic [47:0] near_addr();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60)
			return run_base + 48'($urandom_range(40, 1));
		else if (r < 70)
			return run_base + 48'($urandom_range(BINS - 1, 1));
		else if (r < 75)
			return run_base;
		else if (r < 80)
			return run_base + 48'(BINS - 1);
		else if (r < 85)
			return run_base + 48'(BINS) + 48'($urandom_range(1000));
		else if (r < 92)
			return run_base - 48'($urandom_range(1000, 1));
		else
			return rand_addr();
	endfunction

	task automatic send(input logic [1:0] op, input logic [47:0] addr);
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push    <= 1'b1;
		in_item <= {op, addr};
		@(posedge clk);
		while (full)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_limit(input logic [7:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic run_random(input int unsigned n);
		int unsigned stop;
		int unsigned k;
		stop = sent + n;
		while (sent < stop) begin
			if ($urandom_range(99) < 15) begin
				send(2'($urandom_range(3)), rand_addr());
			end else begin
				// most runs restart; the rest keep counting against the old base
				if ($urandom_range(99) < 75) begin
					send(OP_BEGIN, rand_addr());
					run_base = rand_addr();
					send(OP_INSTR, run_base);
				end
				k = $urandom_range(10);
				repeat (k)
					send(OP_INSTR, near_addr());
				send(OP_END, rand_addr());
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		in_item    = '0;
		cfg_we     = 1'b0;
		cfg_data   = '0;
		tx_idle    = 24;
		rx_idle    = 66;
		sent       = 0;
		run_base   = '0;
		last_limit = '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed: base capture, bin edges, wrap below base, runs, stale limit at reset value
		send(OP_INSTR, 48'h0);
		send(OP_INSTR, 48'h0);
		send(OP_INSTR, 48'h1);
		send(OP_INSTR, 48'h1);
		send(OP_INSTR, 48'(BINS - 1));
		send(OP_INSTR, 48'(BINS));
		send(OP_INSTR, 48'hFFFF_FFFF_FFFF);
		send(OP_NOP, 48'hFFFF_FFFF_FFFF);
		send(OP_END, 48'h0);
		send(OP_INSTR, 48'h2);
		send(OP_END, 48'h0);
		send(OP_BEGIN, 48'hFFFF_FFFF_FFFF);
		send(OP_INSTR, 48'hFFFF_FFFF_FFFF);
		send(OP_INSTR, 48'h0);
		send(OP_INSTR, 48'hFFFF_FFFF_FFFE);
		repeat (7)
			send(OP_END, 48'h0);
		send(OP_BEGIN, 48'h0);
		send(OP_END, 48'h0);
		drain();

		set_limit(8'd0);
		run_random(35);
		drain();
		run_random(35);
		drain();

		set_limit(8'd255);
		tx_idle = 66;
		rx_idle = 24;
		// stale count driven into saturation
		send(OP_BEGIN, rand_addr());
		repeat (270)
			send(OP_END, rand_addr());
		run_random(35);
		drain();

		last_limit = 8'($urandom_range(254, 1));
		set_limit(last_limit);
		tx_idle = 0;
		rx_idle = 0;
		run_random(45);
		drain();
		repeat (20)
			@(posedge clk);

		$display("Covered %0d requests: directed bin edges, random runs, stale saturation burst;",
			sent);
		$display("stale_limit 5, 0, 255 and %0d; %0d reports compared.", last_limit, checked);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
